/* rtl/ede_pkg.sv */
// Package for the Euclidean distance engine: widths, limits, shared types.
// Used by every module under rtl/.
package ede_pkg;

  localparam int FIELD_W    = 16;                 // width of an element field on the bus
  localparam int ELEM_WIDTH = 16;                 // bits of each field that carry the element
  localparam int MAG_W      = ELEM_WIDTH;         // |a - b| fits in ELEM_WIDTH bits
  localparam int SQ_W       = 2 * MAG_W;          // squared difference
  localparam int SUM_W      = 44;                 // running sum, Q28.16
  localparam int DIST_W     = 22;                 // floor square root of the sum
  localparam int IN_DATA_W  = 2 * FIELD_W;
  localparam int OUT_DATA_W = ((DIST_W + SUM_W + 7) / 8) * 8;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};
  // One-hot seed of the root search: highest power of four below 2^SUM_W.
  localparam logic [SUM_W-1:0] ROOT_SEED = {2'b01, {(SUM_W - 2){1'b0}}};

  // Finished sum handed from the front part to the queue.
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } sum_push_t;

  // Queue occupancy seen by both neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_RUN,
    SQ_DONE
  } sqrt_state_t;

endpackage

/* rtl/euclidean_distance_engine_unit.sv */
// Top level of the Euclidean distance engine.
// Instantiates ede_front, ede_fifo and ede_sqrt_back; depends on ede_pkg.
//
// Usage:
//   Input stream (in_*): one element pair per request, elem_a in
//   in_tdata[15:0] and elem_b in in_tdata[31:16], both signed Q8.8;
//   in_tlast marks the final pair of a vector.
//   Output stream (out_*): one request per vector, distance (floor square
//   root, Q14.8) in out_tdata[21:0], saturated sum of squares (Q28.16) in
//   out_tdata[65:22], upper bits zero.
// Throughput: one element pair per cycle while in_tready is high. The front
//   pipe registers the difference, the square and the running sum in turn.
// After the last pair is accepted, its sum finishes the front pipe, is
//   loaded from the queue, runs through the root iterations and is then
//   written to the output register, where out_tvalid rises.
//   The root unit works on one sum at a time, so vectors with fewer pairs than
//   the cycles it spends on a sum are limited by it; the two-entry queue absorbs bursts.
// Stall: when out_tready is low the result holds in the output register,
//   the root unit waits, the queue fills, and then in_tready drops.
// Reset: rst_n (synchronous, active low) clears the running sum, the queue
//   and all valid flags; the block accepts pairs in the first cycle after.
module euclidean_distance_engine_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ede_pkg::IN_DATA_W-1:0]   in_tdata,   // elem_a [15:0], elem_b [31:16]
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ede_pkg::OUT_DATA_W-1:0]  out_tdata   // distance [21:0], sum_squares [65:22]
);
  import ede_pkg::*;

  sum_push_t        push;
  fifo_stat_t       fifo_stat;
  logic             fifo_pop;
  logic [SUM_W-1:0] fifo_data;

  // Accept pairs, square and accumulate; push the sum on the last pair.
  ede_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .fifo_stat (fifo_stat),
    .push      (push)
  );

  // Hold finished sums until the root unit is free.
  ede_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop     (fifo_pop),
    .rd_data (fifo_data),
    .stat    (fifo_stat)
  );

  // Take the root and drive the result stream.
  ede_sqrt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_stat  (fifo_stat),
    .fifo_data  (fifo_data),
    .fifo_pop   (fifo_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* rtl/ede_front.sv */
// Front part of the distance engine: accept element pairs, square the
// difference and accumulate with saturation. Depends on ede_pkg.
module ede_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [ede_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                         in_tlast,
  input  ede_pkg::fifo_stat_t          fifo_stat,
  output ede_pkg::sum_push_t           push
);
  import ede_pkg::*;

  logic                    s1_valid_r, s1_valid_nxt;
  logic [MAG_W-1:0]        s1_mag_r;
  logic                    s1_last_r;
  logic                    s2_valid_r, s2_valid_nxt;
  logic [SQ_W-1:0]         s2_sq_r;
  logic                    s2_last_r;
  logic [SUM_W-1:0]        sum_r, sum_nxt;

  logic                    advance;
  logic signed [MAG_W:0]   a_s, b_s, diff;
  logic [MAG_W:0]          diff_abs;
  logic [SUM_W:0]          sum_ext;
  logic [SUM_W-1:0]        sum_sat;

  // Stall the whole pipe only when a finished sum has nowhere to go.
  assign advance   = !(s2_valid_r && s2_last_r && fifo_stat.full);
  assign in_tready = advance;

  always_comb begin
    a_s      = {in_tdata[ELEM_WIDTH-1], in_tdata[ELEM_WIDTH-1:0]};
    b_s      = {in_tdata[FIELD_W+ELEM_WIDTH-1], in_tdata[FIELD_W+ELEM_WIDTH-1:FIELD_W]};
    diff     = a_s - b_s;
    diff_abs = diff[MAG_W] ? (MAG_W + 1)'(-diff) : diff;
  end

  always_comb begin
    sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(s2_sq_r);
    sum_sat = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s2_valid_nxt = s2_valid_r;
    sum_nxt      = sum_r;
    if (advance) begin
      s1_valid_nxt = in_tvalid;
      s2_valid_nxt = s1_valid_r;
      if (s2_valid_r) begin
        sum_nxt = s2_last_r ? '0 : sum_sat;
      end
    end
  end

  assign push.valid = s2_valid_r && s2_last_r && advance;
  assign push.sum   = sum_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      sum_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      sum_r      <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mag_r  <= diff_abs[MAG_W-1:0];
      s1_last_r <= in_tlast;
      s2_sq_r   <= SQ_W'(s1_mag_r) * SQ_W'(s1_mag_r);
      s2_last_r <= s1_last_r;
    end
  end

endmodule

/* rtl/ede_fifo.sv */
// Short queue of finished sums between the accumulator and the root unit.
// Depends on ede_pkg.
module ede_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ede_pkg::sum_push_t       push,
  input  logic                     pop,
  output logic [ede_pkg::SUM_W-1:0] rd_data,
  output ede_pkg::fifo_stat_t      stat
);
  import ede_pkg::*;

  logic [SUM_W-1:0]      mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign stat.full  = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push.valid && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.sum;
    end
  end

endmodule

/* rtl/ede_sqrt_back.sv */
// Back part of the distance engine: one-bit-per-cycle floor square root of
// each queued sum, and the result output register. Depends on ede_pkg.
module ede_sqrt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ede_pkg::fifo_stat_t           fifo_stat,
  input  logic [ede_pkg::SUM_W-1:0]     fifo_data,
  output logic                          fifo_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ede_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ede_pkg::*;

  sqrt_state_t       state_r, state_nxt;
  logic [SUM_W-1:0]  rem_r, sum_r, bit_r, res_r;
  logic [SUM_W-1:0]  rem_step, res_step;
  logic [SUM_W:0]    trial;
  logic              load, step, emit;
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] dist_out_r;
  logic [SUM_W-1:0]  sum_out_r;

  // One digit of the root per cycle.
  always_comb begin
    trial = {1'b0, res_r} + {1'b0, bit_r};
    if ({1'b0, rem_r} >= trial) begin
      rem_step = rem_r - trial[SUM_W-1:0];
      res_step = (res_r >> 1) + bit_r;
    end else begin
      rem_step = rem_r;
      res_step = res_r >> 1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_IDLE: if (!fifo_stat.empty) state_nxt = SQ_RUN;
      SQ_RUN:  if (bit_r[0]) state_nxt = SQ_DONE;
      SQ_DONE: if (!out_valid_r || out_tready) state_nxt = SQ_IDLE;
      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    step = 1'b0;
    emit = 1'b0;
    unique case (state_r)
      SQ_IDLE: load = !fifo_stat.empty;
      SQ_RUN:  step = 1'b1;
      SQ_DONE: emit = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign fifo_pop = load;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (emit)       out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= fifo_data;
      sum_r <= fifo_data;
      res_r <= '0;
      bit_r <= ROOT_SEED;
    end else if (step) begin
      rem_r <= rem_step;
      res_r <= res_step;
      bit_r <= bit_r >> 2;
    end
    if (emit) begin
      dist_out_r <= res_r[DIST_W-1:0];
      sum_out_r  <= sum_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - DIST_W - SUM_W)'(0), sum_out_r, dist_out_r};

endmodule

/* tb/ede_l2_checker.sv */
// Checker for the Euclidean distance engine: follows both streams, predicts
// each vector's sum of squares and floor root, and compares every result.
// Depends on ede_pkg for the bus widths and the saturation limit.
module ede_l2_checker
  import ede_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    fail_count,
  output int                    pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAD_W      = OUT_DATA_W - DIST_W - SUM_W;
  localparam int REPORT_MAX = 10;

  // Result request as it sits on out_tdata, highest field first.
  typedef struct packed {
    logic [PAD_W-1:0]  pad;
    logic [SUM_W-1:0]  sum_squares;
    logic [DIST_W-1:0] distance;
  } l2_result_t;

  l2_result_t       expected_results[$];
  logic [SUM_W-1:0] sum_of_squares;

  // Square of the element difference; only the low ELEM_WIDTH bits count.
  function automatic logic [SUM_W-1:0] diff_square(logic [FIELD_W-1:0] raw_a,
                                                   logic [FIELD_W-1:0] raw_b);
    logic signed [ELEM_WIDTH-1:0] a;
    logic signed [ELEM_WIDTH-1:0] b;
    longint                       d;
    a = raw_a[ELEM_WIDTH-1:0];
    b = raw_b[ELEM_WIDTH-1:0];
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return SUM_W'(d * d);
  endfunction

  // Digit-by-digit integer square root, rounded down.
  function automatic logic [DIST_W-1:0] floor_root(logic [SUM_W-1:0] value);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = 64'(value);
    root  = '0;
    probe = 64'd1 << 42;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return DIST_W'(root);
  endfunction

  always @(posedge clk) begin
    l2_result_t     seen;
    l2_result_t     want;
    logic [SUM_W:0] total;
    if (!rst_n) begin
      sum_of_squares = '0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen = out_tdata;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t: result with none waiting: dist=%0d sum=%0d", $realtime,
                     seen.distance, seen.sum_squares);
        end else begin
          want = expected_results.pop_front();
          if (seen != want) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("%0t: mismatch dist exp=%0d got=%0d sum exp=%0d got=%0d pad=%0h",
                       $realtime, want.distance, seen.distance, want.sum_squares,
                       seen.sum_squares, seen.pad);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        total = {1'b0, sum_of_squares} +
                diff_square(in_tdata[FIELD_W-1:0], in_tdata[2*FIELD_W-1:FIELD_W]);
        sum_of_squares = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
        if (in_tlast) begin
          want.pad         = '0;
          want.sum_squares = sum_of_squares;
          want.distance    = floor_root(sum_of_squares);
          expected_results = {expected_results, want};
          sum_of_squares = '0;
        end
      end
    end
    pending_results = expected_results.size();
  end

endmodule

/* tb/tb_euclidean_distance_engine_unit.sv */
// Testbench top for euclidean_distance_engine_unit: drives element pairs,
// stalls the result side, and reports the verdict of ede_l2_checker.
// Depends on ede_pkg, the engine RTL and tb/ede_l2_checker.sv.
module tb_euclidean_distance_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ede_pkg::*;

  localparam int IDLE_PCT     = 24;    // chance in percent of an idle cycle per side
  localparam int HOLD_CYCLES  = 300;   // long back-pressure on the result side
  localparam int DRAIN_CYCLES = 40;    // wait after the last result is delivered
  localparam int STALL_LIMIT  = 2000;  // cycles without any request before giving up
  localparam int RANDOM_PAIRS = 690;
  localparam int QUIET_FROM   = 300;   // random pairs sent with no idling at all
  localparam int QUIET_TO     = 450;
  localparam int LONG_DIM     = 64;    // long vector at the largest difference

  localparam logic [FIELD_W-1:0] E_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic [FIELD_W-1:0] E_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // elem_a [15:0], elem_b [31:16]
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // distance [21:0], sum_squares [65:22], zero pad above

  logic quiet_run;      // suppress idling on both sides
  logic hold_request;   // ask the receiver for one long hold-off
  int   fail_count;
  int   pending_results;
  int   stall_cycles;

  euclidean_distance_engine_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ede_l2_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random ready at each falling edge; on request, hold ready low
  // for HOLD_CYCLES counted here, then drop the request flag.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_tready <= quiet_run || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: end the run if no request moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Element value biased toward the extremes and small values around zero.
  function automatic logic [FIELD_W-1:0] pick_element();
    case ($urandom_range(0, 7))
      0:       return E_MAX;
      1:       return E_MIN;
      2:       return '0;
      3:       return '1;
      4:       return FIELD_W'($urandom_range(0, 511)) - FIELD_W'(256);
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // Offer one pair request: idle a random number of cycles, then hold it
  // until accepted. Valid stays high into the next call when no idle comes.
  task automatic send_pair(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b,
                           input logic last);
    int gap;
    gap = 0;
    while (!quiet_run && $urandom_range(0, 99) < IDLE_PCT) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_vector(input int len);
    for (int i = 0; i < len; i++)
      send_pair(pick_element(), pick_element(), i == len - 1);
  endtask

  // Drop valid and wait until every predicted result has been delivered.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  initial begin
    int sent;
    int len;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    quiet_run    = 1'b0;
    hold_request = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: single-pair vectors at the field extremes, alternating bit
    // patterns, and short multi-pair vectors.
    send_pair('0, '0, 1'b1);                       // zero distance
    send_pair(E_MAX, E_MIN, 1'b1);                 // largest positive difference
    send_pair(E_MIN, E_MAX, 1'b1);                 // largest negative difference
    send_pair(E_MIN, E_MIN, 1'b1);
    send_pair(E_MAX, E_MAX, 1'b1);
    send_pair(16'h0001, '0, 1'b1);                 // smallest nonzero sum
    send_pair('0, 16'hFFFF, 1'b1);
    send_pair(16'h5555, 16'hAAAA, 1'b0);
    send_pair(16'hAAAA, 16'h5555, 1'b1);
    send_pair(16'h0100, 16'hFF00, 1'b0);           // +1.0 against -1.0
    send_pair(16'h0300, '0, 1'b0);
    send_pair(16'h0400, '0, 1'b1);
    send_pair(16'hFFFF, 16'h0001, 1'b0);
    send_pair(16'h7F00, 16'h80FF, 1'b0);
    send_pair(16'h00FF, 16'hFF01, 1'b1);
    send_pair(16'h1234, 16'h1233, 1'b1);

    // Long vector with every pair at the largest difference.
    for (int i = 0; i < LONG_DIM; i++)
      send_pair(E_MAX, E_MIN, i == LONG_DIM - 1);

    // Back-pressure: hold the receiver off while short vectors keep coming,
    // so the queue fills and input ready drops.
    hold_request = 1'b1;
    for (int v = 0; v < 40; v++) send_vector($urandom_range(1, 3));
    drain_results();

    // Random vectors, mostly short, a few long; one stretch without idling.
    sent = 0;
    while (sent < RANDOM_PAIRS) begin
      quiet_run = (sent >= QUIET_FROM && sent < QUIET_TO);
      case ($urandom_range(0, 19))
        0:             len = $urandom_range(41, 120);
        1, 2, 3, 4, 5: len = $urandom_range(9, 40);
        default:       len = $urandom_range(1, 8);
      endcase
      send_vector(len);
      sent += len;
    end
    quiet_run = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ede_pkg.sv
rtl/ede_front.sv
rtl/ede_fifo.sv
rtl/ede_sqrt_back.sv
rtl/euclidean_distance_engine_unit.sv
tb/ede_l2_checker.sv
tb/tb_euclidean_distance_engine_unit.sv
